@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SERVE  = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;    // capture a result into the output register
		logic    insert;  // place the new entry into the slots
		logic    serve;   // pop the head slot
		status_t code;    // status to report
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic             empty;
		logic             full;
		logic [CNT_W-1:0] count;
	} spq_stat_t;

endpackage

@@ rtl/spq_ctrl.sv @@
`timescale 1ns / 1ps
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      opcode,
	output logic      out_valid,
	input  logic      out_stall,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// a new transfer is taken whenever the output register is free or drains now
	assign in_stall  = (state_q == S_HOLD) && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = (state_q == S_HOLD);

	always_comb begin
		cmd.load   = accept;
		cmd.insert = 1'b0;
		cmd.serve  = 1'b0;
		cmd.code   = ST_INSERTED;
		if (opcode == OP_INSERT) begin
			if (stat.full) begin
				cmd.code = ST_FULL;
			end else begin
				cmd.code   = ST_INSERTED;
				cmd.insert = accept;
			end
		end else begin
			if (stat.empty) begin
				cmd.code = ST_EMPTY;
			end else begin
				cmd.code  = ST_SERVED;
				cmd.serve = accept;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (!out_stall && !accept) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/spq_datapath.sv @@
`timescale 1ns / 1ps
module spq_datapath import spq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_cmd_t           cmd,
	input  logic signed [31:0] entry_id,
	input  logic signed [31:0] urgency,
	output spq_stat_t          stat,
	output logic        [1:0]  status,
	output logic signed [31:0] served_id
);

	logic signed [31:0] id_q  [CAPACITY];
	logic signed [31:0] urg_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	status_t            status_q;
	logic signed [31:0] served_id_q;

	logic               keep [CAPACITY];
	logic signed [31:0] id_d  [CAPACITY];
	logic signed [31:0] urg_d [CAPACITY];

	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(CAPACITY));

	// slots stay sorted, so "keep" is a prefix; the first slot that drops it takes
	// the new entry and every slot behind it moves back by one
	always_comb begin
		keep[0] = !(stat.empty || (urgency > urg_q[0]));
		for (int i = 1; i < CAPACITY; i++) begin
			keep[i] = keep[i-1] && (CNT_W'(i) < count_q) && (urg_q[i] > urgency);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			id_d[i]  = id_q[i];
			urg_d[i] = urg_q[i];
		end
		if (cmd.insert) begin
			id_d[0]  = keep[0] ? id_q[0]  : entry_id;
			urg_d[0] = keep[0] ? urg_q[0] : urgency;
			for (int i = 1; i < CAPACITY; i++) begin
				if (!keep[i]) begin
					id_d[i]  = keep[i-1] ? entry_id : id_q[i-1];
					urg_d[i] = keep[i-1] ? urgency  : urg_q[i-1];
				end
			end
		end else if (cmd.serve) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				id_d[i]  = id_q[i+1];
				urg_d[i] = urg_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			id_q[i]  <= id_d[i];
			urg_q[i] <= urg_d[i];
		end
		if (cmd.load) begin
			status_q    <= cmd.code;
			served_id_q <= cmd.serve ? id_q[0] : 32'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.serve) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign status    = status_q;
	assign served_id = served_id_q;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
`timescale 1ns / 1ps
// channel | handshake            | payload
// --------+----------------------+-----------------------------------------
// in      | in_valid / in_stall  | opcode, entry_id, urgency
// out     | out_valid / out_stall| status, served_id
//
// Each transfer in is executed in the cycle it is accepted: all slots compare
// against the new urgency in parallel and shift in one step, and the result is
// captured in the output register. One item per cycle while out drains.
// Reset (arst_n low) empties the queue and the output register; slot contents
// are not cleared, only slots below the entry count are ever read.
// in_stall rises only while a result is held and out_stall is high.
module sorted_priority_queue_core import spq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic signed [31:0] entry_id,
	input  logic signed [31:0] urgency,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [1:0]  status,
	output logic signed [31:0] served_id
);

	spq_cmd_t  cmd;
	spq_stat_t stat;

	// sequencing: accept, decide the action and hold the result
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot shift register, entry count and output register
	spq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.entry_id  (entry_id),
		.urgency   (urgency),
		.stat      (stat),
		.status    (status),
		.served_id (served_id)
	);

`ifndef NO_ASSERTIONS
	// never hold more entries than slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// only a served result carries an id
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_SERVED) |-> served_id == 32'sd0)
		else $error("nonzero served_id without serve");

	// serve on an empty queue reports empty
	a_serve_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_SERVE && stat.empty)
		|=> (out_valid && status == ST_EMPTY))
		else $error("empty serve not reported");

	// a dropped insert leaves the count unchanged
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_INSERT && stat.full)
		|=> ($stable(stat.count) && status == ST_FULL))
		else $error("insert into full queue changed state");
`endif

endmodule

@@ tb/queue_order_checker.sv @@
`timescale 1ns / 1ps
module queue_order_checker import spq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               opcode,
	input  logic signed [31:0] entry_id,
	input  logic signed [31:0] urgency,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic        [1:0]  status,
	input  logic signed [31:0] served_id,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		status_t            code;
		logic signed [31:0] id;
	} queue_result_t;

	queue_result_t due_results[$];

	// shadow copy of the slots, head at index 0
	logic signed [31:0] shadow_id  [CAPACITY];
	logic signed [31:0] shadow_urg [CAPACITY];
	int                 shadow_len;

	initial mismatches = 0;

	task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
	endtask

	task automatic advance_shadow(input logic op, input logic signed [31:0] id,
			input logic signed [31:0] urg, output queue_result_t r);
		int pos;
		int k;
		r.id = '0;
		if (op == OP_INSERT) begin
			if (shadow_len == CAPACITY) begin
				r.code = ST_FULL;
			end else begin
				// head only yields to a strictly greater urgency
				if (shadow_len == 0 || urg > shadow_urg[0]) begin
					pos = 0;
				end else begin
					pos = 1;
					while (pos < shadow_len && shadow_urg[pos] > urg)
						pos++;
				end
				for (k = shadow_len; k > pos; k--) begin
					shadow_id[k]  = shadow_id[k-1];
					shadow_urg[k] = shadow_urg[k-1];
				end
				shadow_id[pos]  = id;
				shadow_urg[pos] = urg;
				shadow_len++;
				r.code = ST_INSERTED;
			end
		end else if (shadow_len == 0) begin
			r.code = ST_EMPTY;
		end else begin
			r.code = ST_SERVED;
			r.id   = shadow_id[0];
			for (k = 0; k < shadow_len - 1; k++) begin
				shadow_id[k]  = shadow_id[k+1];
				shadow_urg[k] = shadow_urg[k+1];
			end
			shadow_len--;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t oldest;
		queue_result_t fresh;
		if (!arst_n) begin
			due_results.delete();
			shadow_len  = 0;
			outstanding = 0;
		end else begin
			// results are registered, so check the output before taking new input
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					note_mismatch("unexpected result, status", -1, status);
				end else begin
					oldest = due_results.pop_front();
					if (status !== oldest.code)
						note_mismatch("status", oldest.code, status);
					if (served_id !== oldest.id)
						note_mismatch("served_id", oldest.id, served_id);
				end
			end
			if (in_valid && !in_stall) begin
				advance_shadow(opcode, entry_id, urgency, fresh);
				due_results.push_back(fresh);
			end
			outstanding = due_results.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top import spq_pkg::*;;

	localparam int RANDOM_ITEMS = 400;
	localparam int PHASE_ITEMS  = 50;
	// worst case run time is well under this watchdog limit
	localparam int CYCLE_LIMIT  = 200000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               opcode;
	logic signed [31:0] entry_id;
	logic signed [31:0] urgency;
	logic               out_valid;
	logic               out_stall;
	logic        [1:0]  status;
	logic signed [31:0] served_id;

	int mismatches;
	int outstanding;
	int cycles;
	int out_xfers;
	bit sender_quiet;
	bit long_hold_done;
	int serve_pct;

	sorted_priority_queue_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.entry_id  (entry_id),
		.urgency   (urgency),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.served_id (served_id)
	);

	queue_order_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.entry_id    (entry_id),
		.urgency     (urgency),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.served_id   (served_id),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: stop a hung run.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[sorted_priority_queue_core] ERROR");
			$finish;
		end
	end

	// Count result transfers so the receiver knows when to start its long hold.
	initial out_xfers = 0;
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			out_xfers++;

	// Receiver: mix free runs (some long, so there are stretches with no
	// stalling) with short and occasional long stalls. Once, after the
	// stream is under way, hold off for a long stretch so that the result
	// register stays full and the block pushes back on its input.
	initial begin
		int r;
		int len;
		out_stall      = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && out_xfers >= 60) begin
				out_stall <= 1'b1;
				repeat (79) @(negedge clk);
				long_hold_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_stall <= 1'b0;
					len = $urandom_range(1, 30);
				end else if (r < 85) begin
					out_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					len = $urandom_range(4, 20);
				end
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	// Idle cycles between transfers in: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		if (sender_quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Favor a narrow band so that ties are common, and hit the extremes.
	function automatic logic signed [31:0] pick_urgency();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $signed(32'($urandom_range(0, 6))) - 32'sd3;
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fff_ffff;
				1: return 32'sh8000_0000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $signed($urandom());
	endfunction

	// Present one item and hold it until the block takes it, then idle if a gap is picked.
	task automatic send_item(input logic op, input logic signed [31:0] id,
			input logic signed [31:0] urg);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode   <= op;
		entry_id <= id;
		urgency  <= urg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every predicted result has been seen.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_INSERT;
		entry_id     = '0;
		urgency      = '0;
		sender_quiet = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part.
		// Serve on an empty queue.
		send_item(OP_SERVE, 32'sd0, 32'sd0);
		// First entry becomes the head; an equal urgency goes right behind it.
		send_item(OP_INSERT, 32'sh7fff_ffff, 32'sd0);
		send_item(OP_INSERT, 32'sh8000_0000, 32'sd0);
		// Strictly greater urgency displaces the head; minimum goes to the tail.
		send_item(OP_INSERT, 32'sd1, 32'sh7fff_ffff);
		send_item(OP_INSERT, -32'sd1, 32'sh8000_0000);
		// Tie with the head at the top urgency.
		send_item(OP_INSERT, 32'sd5, 32'sh7fff_ffff);
		send_item(OP_INSERT, 32'sd6, -32'sd1);
		send_item(OP_INSERT, 32'sd7, 32'sd1);
		send_item(OP_INSERT, 32'sd8, 32'sd0);
		send_item(OP_INSERT, 32'sd9, 32'sd0);
		send_item(OP_INSERT, 32'sd10, -32'sd1);
		send_item(OP_INSERT, 32'sd11, 32'sd100);
		send_item(OP_INSERT, 32'sd12, 32'sh8000_0000);
		send_item(OP_INSERT, 32'sd13, 32'sh4000_0000);
		send_item(OP_INSERT, 32'sh5555_5555, 32'shaaaa_aaaa);
		send_item(OP_INSERT, 32'shaaaa_aaaa, 32'sh5555_5555);
		// This insert takes the last free slot, so the queue is full after it.
		send_item(OP_INSERT, 32'sd99, 32'sh7fff_ffff);
		send_item(OP_SERVE, 32'sd0, 32'sd0);
		send_item(OP_SERVE, 32'sd0, 32'sd0);
		send_item(OP_INSERT, 32'sd20, 32'sh7fff_ffff);
		send_item(OP_SERVE, 32'sd0, 32'sd0);

		// Random part: the serve share changes per phase, so the queue swings
		// between full and empty; some phases run with no idling at all.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % PHASE_ITEMS == 0) begin
				case ($urandom_range(0, 4))
					0: serve_pct = 10;
					1: serve_pct = 30;
					2: serve_pct = 50;
					3: serve_pct = 70;
					default: serve_pct = 90;
				endcase
				sender_quiet = ($urandom_range(0, 3) == 0);
			end
			// Pause once mid-run until the queue of results has drained.
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			if ($urandom_range(0, 99) < serve_pct)
				send_item(OP_SERVE, $signed($urandom()), $signed($urandom()));
			else
				send_item(OP_INSERT, $signed($urandom()), pick_urgency());
		end

		drain_results();
		repeat (5) @(negedge clk);
		if (mismatches == 0)
			$display("[sorted_priority_queue_core] OK");
		else
			$display("[sorted_priority_queue_core] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue_core.sv
tb/queue_order_checker.sv
tb/tb_top.sv
